### design/lis_pkg.sv
// shared types and constants for the longest increasing subsequence block
package lis_pkg;

	localparam int LenW = 16;
	localparam int EpochW = 4;
	localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};
	localparam logic [EpochW-1:0] EpochMax = {EpochW{1'b1}};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QUERY,
		ST_LEAF,
		ST_CLIMB,
		ST_DONE
	} lis_state_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic q_step;
		logic u_leaf;
		logic u_step;
		logic publish;
	} lis_cmd_t;

	typedef struct packed {
		logic wrap;
		logic clr_last;
		logic q_done;
		logic u_last;
	} lis_sts_t;

endpackage

### design/lis_dp.sv
// datapath: tree memory with epoch tags, query and update walkers, result registers
module lis_dp #(
	parameter int LEAVES = 32768
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lis_pkg::lis_cmd_t             cmd,
	output lis_pkg::lis_sts_t             sts,
	input  logic                          start_new,
	input  logic signed [14:0]            value,
	output logic [lis_pkg::LenW-1:0]      element_length,
	output logic [lis_pkg::LenW-1:0]      best_length
);

	localparam int LW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam int AW = $clog2(2 * LEAVES);
	localparam int DEPTH = 2 * LEAVES;
	localparam int WW = lis_pkg::EpochW + lis_pkg::LenW;
	localparam logic [AW-1:0] LeafBase = AW'(LEAVES);
	localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

	logic [WW-1:0] mem [DEPTH];

	logic [lis_pkg::EpochW-1:0] epoch_q;
	logic [lis_pkg::LenW-1:0]   best_q, acc_q, cur_q, elen_q;
	logic [lis_pkg::LenW-1:0]   len_out_q, best_out_q;
	logic [AW-1:0]              lo_q, hi_q, node_q, clr_addr_q;
	logic                       pa_s1, pb_s1;
	logic [WW-1:0]              rda_s1, rdb_s1;

	logic [AW-1:0]              ra, rb, wa;
	logic [WW-1:0]              wd;
	logic                       we;
	logic                       en_a, en_b, lt;
	logic [lis_pkg::LenW-1:0]   da, db, merged, elen, parent;
	logic signed [31:0]         pos;
	logic [LW-1:0]              leaf;
	logic [AW-1:0]              up;

	// stale epoch reads as an empty entry
	assign da = (rda_s1[WW-1 -: lis_pkg::EpochW] == epoch_q) ? rda_s1[lis_pkg::LenW-1:0] : '0;
	assign db = (rdb_s1[WW-1 -: lis_pkg::EpochW] == epoch_q) ? rdb_s1[lis_pkg::LenW-1:0] : '0;

	always_comb begin
		pos = 32'(value) + 32'(LEAVES / 2);
		if (pos < 0) begin
			leaf = '0;
		end else if (pos >= 32'(LEAVES)) begin
			leaf = LW'(LEAVES - 1);
		end else begin
			leaf = pos[LW-1:0];
		end
	end

	assign lt = lo_q < hi_q;
	assign en_a = lt & lo_q[0];
	assign en_b = lt & hi_q[0];
	assign up = node_q >> 1;

	always_comb begin
		merged = acc_q;
		if (pa_s1 && da > merged) merged = da;
		if (pb_s1 && db > merged) merged = db;
	end

	assign elen = (acc_q == lis_pkg::LenMax) ? acc_q : acc_q + 1'b1;
	assign parent = (db > cur_q) ? db : cur_q;

	always_comb begin
		ra = lo_q;
		rb = hi_q - 1'b1;
		we = 1'b0;
		wa = clr_addr_q;
		wd = '0;
		if (cmd.u_leaf) begin
			rb = node_q ^ AW'(1);
			we = 1'b1;
			wa = node_q;
			wd = {epoch_q, elen};
		end else if (cmd.u_step) begin
			rb = up ^ AW'(1);
			we = 1'b1;
			wa = up;
			wd = {epoch_q, parent};
		end else if (cmd.clr_step) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rda_s1 <= mem[ra];
		rdb_s1 <= mem[rb];
		if (we) mem[wa] <= wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= '0;
			best_q <= '0;
			clr_addr_q <= '0;
			pa_s1 <= 1'b0;
			pb_s1 <= 1'b0;
		end else begin
			pa_s1 <= cmd.q_step & en_a;
			pb_s1 <= cmd.q_step & en_b;
			if (cmd.load && start_new) begin
				best_q <= '0;
				if (epoch_q == lis_pkg::EpochMax) begin
					epoch_q <= '0;
					clr_addr_q <= '0;
				end else begin
					epoch_q <= epoch_q + 1'b1;
				end
			end
			if (cmd.clr_step) clr_addr_q <= clr_addr_q + 1'b1;
			if (cmd.u_leaf && elen > best_q) best_q <= elen;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q <= LeafBase;
			hi_q <= AW'(leaf) + LeafBase;
			node_q <= AW'(leaf) + LeafBase;
			acc_q <= '0;
		end else begin
			acc_q <= merged;
			if (cmd.q_step) begin
				lo_q <= (lo_q + AW'(lo_q[0])) >> 1;
				hi_q <= hi_q >> 1;
			end
		end
		if (cmd.u_leaf) begin
			cur_q <= elen;
			elen_q <= elen;
		end
		if (cmd.u_step) begin
			cur_q <= parent;
			node_q <= up;
		end
		if (cmd.publish) begin
			len_out_q <= elen_q;
			best_out_q <= best_q;
		end
	end

	assign sts.wrap = start_new & (epoch_q == lis_pkg::EpochMax);
	assign sts.clr_last = clr_addr_q == LastAddr;
	assign sts.q_done = !lt;
	assign sts.u_last = up == AW'(1);

	assign element_length = len_out_q;
	assign best_length = best_out_q;

endmodule

### design/lis_ctrl.sv
// controller state machine: clearing pass, query walk, update climb, result handoff
module lis_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  lis_pkg::lis_sts_t   sts,
	output lis_pkg::lis_cmd_t   cmd
);

	lis_pkg::lis_state_t state_q, state_d;
	logic item_q, item_d, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lis_pkg::ST_CLEAR;
			item_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			item_q <= item_d;
			out_valid_q <= cmd.publish | (out_valid_q & out_stall);
		end
	end

	always_comb begin
		state_d = state_q;
		item_d = item_q;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			lis_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = item_q ? lis_pkg::ST_QUERY : lis_pkg::ST_IDLE;
					item_d = 1'b0;
				end
			end
			lis_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.wrap) begin
						state_d = lis_pkg::ST_CLEAR;
						item_d = 1'b1;
					end else begin
						state_d = lis_pkg::ST_QUERY;
					end
				end
			end
			lis_pkg::ST_QUERY: begin
				if (sts.q_done) state_d = lis_pkg::ST_LEAF;
				else cmd.q_step = 1'b1;
			end
			lis_pkg::ST_LEAF: begin
				cmd.u_leaf = 1'b1;
				state_d = lis_pkg::ST_CLIMB;
			end
			lis_pkg::ST_CLIMB: begin
				cmd.u_step = 1'b1;
				if (sts.u_last) state_d = lis_pkg::ST_DONE;
			end
			lis_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.publish = 1'b1;
					state_d = lis_pkg::ST_IDLE;
				end
			end
			default: state_d = lis_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### design/longest_increasing_subsequence.sv
// top level of the longest increasing subsequence block
// Streams signed values and returns, per value, the longest strictly increasing
// subsequence ending at it and the longest seen since the last restart. A max
// segment tree over LEAVES leaves (value plus LEAVES/2, saturated at both ends)
// lives in one memory with one write and two read ports. The query stops once
// its range is empty, so it ends sooner for leaves in the lower half: the
// query climbs one level a cycle reading both range edges at once, then the
// update climbs one level a cycle reading the sibling and writing the parent.
// A restart bumps a tree epoch tag instead of clearing; stale entries read as
// zero. After reset, and every 16th restart when the tag wraps, a clearing
// pass sweeps the memory with input stalled. The next input transfer is taken
// while a result still waits in the output register.
module longest_increasing_subsequence #(
	parameter int LEAVES = 32768
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               start_new,
	input  logic signed [14:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        element_length,
	output logic [15:0]        best_length
);

	// command and status between controller and datapath
	lis_pkg::lis_cmd_t cmd;
	lis_pkg::lis_sts_t sts;

	lis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lis_dp #(
		.LEAVES (LEAVES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.start_new      (start_new),
		.value          (value),
		.element_length (element_length),
		.best_length    (best_length)
	);

endmodule
